### rtl/smpq_pkg.sv
// Shared types and codes for the stable max-first priority queue.
package smpq_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned StatusW = 2;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_POP    = 1'b1
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_POP_EMPTY = 2'd1,
    STATUS_FULL      = 2'd2
  } status_e;

  // One stored pair and its occupancy flag.
  typedef struct packed {
    logic                    valid;
    logic signed [DataW-1:0] number;
    logic signed [DataW-1:0] prio;
  } entry_t;

  // Operation broadcast to every cell in the cycle an item is accepted.
  typedef struct packed {
    logic                    ins;
    logic                    pop;
    logic signed [DataW-1:0] number;
    logic signed [DataW-1:0] prio;
  } cmd_t;

endpackage

### rtl/smpq_cell.sv
// One storage cell of the sorted shift chain.
module smpq_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  smpq_pkg::cmd_t    cmd_i,
  input  smpq_pkg::entry_t  left_i,
  input  logic              left_place_i,
  input  smpq_pkg::entry_t  right_i,
  output smpq_pkg::entry_t  entry_o,
  output logic              place_o
);

  logic                            valid_q, valid_d;
  logic signed [smpq_pkg::DataW-1:0] number_q, number_d;
  logic signed [smpq_pkg::DataW-1:0] prio_q, prio_d;

  // The new pair lands at or before this cell when the cell is empty or holds a
  // strictly lower priority; equal priorities keep the older pair first.
  assign place_o = !valid_q || (prio_q < cmd_i.prio);

  always_comb begin
    valid_d  = valid_q;
    number_d = number_q;
    prio_d   = prio_q;
    if (cmd_i.ins) begin
      if (place_o && !left_place_i) begin
        valid_d  = 1'b1;
        number_d = cmd_i.number;
        prio_d   = cmd_i.prio;
      end else if (place_o) begin
        valid_d  = left_i.valid;
        number_d = left_i.number;
        prio_d   = left_i.prio;
      end
    end else if (cmd_i.pop) begin
      valid_d  = right_i.valid;
      number_d = right_i.number;
      prio_d   = right_i.prio;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    number_q <= number_d;
    prio_q   <= prio_d;
  end

  assign entry_o = '{valid: valid_q, number: number_q, prio: prio_q};

endmodule

### rtl/stable_max_priority_queue_unit.sv
// Top level of the stable max-first priority queue built as a chain of cells.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item: kind_i selects
//   insert (store number_i with priority_req_i) or pop (remove the entry with
//   the greatest priority, oldest first among equal priorities).
//   Output channel (out_valid_o / out_stall_i) returns one item per accepted
//   input: status_o (ok, pop on empty, insert dropped because full),
//   number_res_o (popped value, else 0) and is_empty_o (queue empty after it).
// Result: the result is registered in the output register in the cycle after
//   the input is accepted.
// Throughput: one item per cycle while in_stall_o is low. Every cell compares
//   its own priority with the broadcast priority and looks only at its
//   neighbors, so an insert or a pop updates the whole sorted chain at once.
// Stall: while a result waits in the output register and out_stall_i is high,
//   in_stall_o is high; the queue holds its contents and the result holds.
// Reset: rst_ni clears all cell valid flags and the output valid flag; the
//   queue starts empty and is ready at once, with no clearing pass.
module stable_max_priority_queue_unit #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 kind_i,
  input  logic signed [smpq_pkg::DataW-1:0]    number_i,
  input  logic signed [smpq_pkg::DataW-1:0]    priority_req_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [smpq_pkg::StatusW-1:0]         status_o,
  output logic signed [smpq_pkg::DataW-1:0]    number_res_o,
  output logic                                 is_empty_o
);

  smpq_pkg::entry_t entry [CAPACITY];
  logic [CAPACITY-1:0] place;
  logic [CAPACITY-1:0] valid_vec;
  smpq_pkg::cmd_t      cmd;

  logic fire, is_pop, full, empty;

  logic                              out_valid_q;
  smpq_pkg::status_e                 status_q, status_d;
  logic signed [smpq_pkg::DataW-1:0] number_res_q, number_res_d;
  logic                              is_empty_q, is_empty_d;

  // Accept whenever the output register is free or drains this cycle.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign fire       = in_valid_i && !in_stall_o;
  assign is_pop     = (smpq_pkg::kind_e'(kind_i) == smpq_pkg::KIND_POP);

  // Valid cells form a prefix: empty and full read straight off the ends.
  assign empty = !valid_vec[0];
  assign full  = valid_vec[CAPACITY-1];

  // Drop inserts into a full queue; a pop on an empty queue shifts only
  // invalid cells and so leaves the queue contents unchanged.
  assign cmd = '{ins:    fire && !is_pop && !full,
                 pop:    fire && is_pop,
                 number: number_i,
                 prio:   priority_req_i};

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    smpq_pkg::entry_t left_e, right_e;
    logic             left_place;

    if (k == 0) begin : g_head
      assign left_e     = '0;
      assign left_place = 1'b0;
    end else begin : g_mid_l
      assign left_e     = entry[k-1];
      assign left_place = place[k-1];
    end

    if (k == CAPACITY-1) begin : g_tail
      assign right_e = '0;
    end else begin : g_mid_r
      assign right_e = entry[k+1];
    end

    smpq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .left_i       (left_e),
      .left_place_i (left_place),
      .right_i      (right_e),
      .entry_o      (entry[k]),
      .place_o      (place[k])
    );

    assign valid_vec[k] = entry[k].valid;
  end

  // Form the result from the head cell and the chain's fill before the update.
  always_comb begin
    status_d     = smpq_pkg::STATUS_OK;
    number_res_d = '0;
    is_empty_d   = 1'b0;
    if (is_pop) begin
      if (empty) begin
        status_d   = smpq_pkg::STATUS_POP_EMPTY;
        is_empty_d = 1'b1;
      end else begin
        number_res_d = entry[0].number;
        is_empty_d   = !valid_vec[1];
      end
    end else if (full) begin
      status_d = smpq_pkg::STATUS_FULL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load the result only on acceptance; hold it otherwise.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q     <= status_d;
      number_res_q <= number_res_d;
      is_empty_q   <= is_empty_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign number_res_o = number_res_q;
  assign is_empty_o   = is_empty_q;

`ifndef SYNTHESIS
  // The occupied cells always form a prefix of the chain.
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot({1'b0, valid_vec} + {{CAPACITY{1'b0}}, 1'b1}))
    else $error("cell valid flags are not a prefix");

  // An accepted insert with room leaves the queue non-empty.
  a_insert_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins |=> (valid_vec[0] && !is_empty_o))
    else $error("insert did not occupy the head cell");

  // A pop on an empty queue reports empty and returns zero.
  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == smpq_pkg::STATUS_POP_EMPTY)
      |-> (is_empty_o && number_res_o == '0))
    else $error("pop on empty queue reported wrong result");

  // The reported emptiness matches the chain after the step.
  a_empty_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (is_empty_o == !valid_vec[0]))
    else $error("is_empty disagrees with the cell chain");
`endif

endmodule
